[rtl/two_key_record_hash_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// two_key_record_hash_table_unit_defines
// assertion macros shared by the hash table rtl, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_RECORD_HASH_TABLE_UNIT_DEFINES_SVH
`define TWO_KEY_RECORD_HASH_TABLE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TKHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TKHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tkht_pkg.sv]
// ----------------------------------------------------------------------------
// tkht_pkg
// sizes, codes and shared types of the two-key record hash table
// ----------------------------------------------------------------------------
package tkht_pkg;

    // table geometry; the bucket count is a power of two of at least two
    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int WORDS     = 8;
    localparam int DATA_W    = 64;

    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS     = BUCKETS * WAYS;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int WADDR_W   = SLOT_W + WIDX_W;

    // operation codes
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // one tag entry: identity pair and the mask of words written since allocation
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] ctx;
        logic [WORDS-1:0]  mask;
    } tag_entry_t;

    // access commands from the sequencer to the record store
    typedef struct packed {
        logic [SLOT_W-1:0]  tag_raddr;
        logic               tag_we;
        logic [SLOT_W-1:0]  tag_waddr;
        tag_entry_t         tag_wdata;
        logic [WADDR_W-1:0] word_raddr;
        logic               word_we;
        logic [WADDR_W-1:0] word_waddr;
        logic [DATA_W-1:0]  word_wdata;
    } store_cmd_t;

    // slot number of one way of a bucket
    function automatic logic [SLOT_W-1:0] slot_index(input logic [BUCKET_W-1:0] bucket,
                                                     input logic [WAY_W-1:0] way);
        return SLOT_W'(bucket) * SLOT_W'(WAYS) + SLOT_W'(way);
    endfunction

endpackage

[rtl/tkht_store.sv]
// ----------------------------------------------------------------------------
// tkht_store
// record storage: tag memory (key, context, written-word mask) and value
// word memory, one write and one registered read port each
// ----------------------------------------------------------------------------
module tkht_store
    import tkht_pkg::*;
(
    input  logic              clk,
    input  store_cmd_t        cmd,
    output tag_entry_t        tag_rdata,
    output logic [DATA_W-1:0] word_rdata
);

    tag_entry_t        tag_mem [SLOTS];
    logic [DATA_W-1:0] word_mem [SLOTS*WORDS];

    tag_entry_t        tag_rdata_reg;
    logic [DATA_W-1:0] word_rdata_reg;

    // tag memory
    always_ff @(posedge clk)
    begin
        if (cmd.tag_we)
        begin
            tag_mem[cmd.tag_waddr] <= cmd.tag_wdata;
        end
        tag_rdata_reg <= tag_mem[cmd.tag_raddr];
    end

    // value word memory
    always_ff @(posedge clk)
    begin
        if (cmd.word_we)
        begin
            word_mem[cmd.word_waddr] <= cmd.word_wdata;
        end
        word_rdata_reg <= word_mem[cmd.word_raddr];
    end

    assign tag_rdata  = tag_rdata_reg;
    assign word_rdata = word_rdata_reg;

endmodule

[rtl/two_key_record_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// two_key_record_hash_table_unit
// set-associative dictionary keyed by (key, context); each record holds
// eight value words that can be written, read, and freed per record
// ----------------------------------------------------------------------------
//  channel  handshake            word
//  in       in_valid / in_stall  operation, key, context_req, word_index, value
//  out      out_valid / out_stall read_value, hit, bucket_full
//
//  an item is handled in order: the word is taken, the ways are compared one
//  per cycle, then the tables are updated and the result registered; the tag
//  memory's single read port feeds one way per cycle to the shared comparator
//  reset clears the per-bucket row flags at once, so no clearing pass is run
//  the next word is taken while a result still waits in the output register;
//  out_stall holds the sequencer in its final cycle until that register frees
// ----------------------------------------------------------------------------
`include "two_key_record_hash_table_unit_defines.svh"

module two_key_record_hash_table_unit
    import tkht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [DATA_W-1:0]        key,
    input  logic [DATA_W-1:0]        context_req,
    input  logic [WIDX_W-1:0]        word_index,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     hit,
    output logic                     bucket_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_ACT
    } state_t;

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]   ctx_reg, ctx_next;
    logic [WIDX_W-1:0]   widx_reg, widx_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic                hit_reg, hit_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic [WORDS-1:0]    hit_mask_reg, hit_mask_next;
    logic                free_found_reg, free_found_next;
    logic [WAY_W-1:0]    free_way_reg, free_way_next;
    logic [BUCKETS-1:0]  row_init_reg, row_init_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_read_reg, out_read_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_full_reg, out_full_next;

    // valid row memory, one row of way bits per bucket
    logic [WAYS-1:0]     vrow_mem [BUCKETS];
    logic [WAYS-1:0]     vrow_rdata_reg;
    logic                vrow_we;
    logic [WAYS-1:0]     vrow_wdata;

    store_cmd_t          cmd;
    tag_entry_t          tag_rdata;
    logic [DATA_W-1:0]   word_rdata;

    logic                accept;
    logic [BUCKET_W-1:0] bucket;
    logic [BUCKET_W-1:0] in_bucket;
    logic [WAYS-1:0]     vrow_eff;
    logic                match;
    logic [WAY_W-1:0]    next_way;
    logic                out_free;

    tkht_store u_store (
        .clk        (clk),
        .cmd        (cmd),
        .tag_rdata  (tag_rdata),
        .word_rdata (word_rdata)
    );

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_bucket = key[BUCKET_W-1:0];
    assign bucket    = key_reg[BUCKET_W-1:0];
    // a row never written since reset reads as all ways free
    assign vrow_eff  = row_init_reg[bucket] ? vrow_rdata_reg : '0;
    assign next_way  = (way_reg == LAST_WAY) ? '0 : way_reg + WAY_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;

    // shared identity comparator
    assign match = vrow_eff[way_reg] && (tag_rdata.key == key_reg)
                   && (tag_rdata.ctx == ctx_reg);

    // valid row memory, read when a word is taken
    always_ff @(posedge clk)
    begin
        if (vrow_we)
        begin
            vrow_mem[bucket] <= vrow_wdata;
        end
        if (accept)
        begin
            vrow_rdata_reg <= vrow_mem[in_bucket];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        ctx_next        = ctx_reg;
        widx_next       = widx_reg;
        value_next      = value_reg;
        way_next        = way_reg;
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        hit_mask_next   = hit_mask_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        row_init_next   = row_init_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_read_next   = out_read_reg;
        out_hit_next    = out_hit_reg;
        out_full_next   = out_full_reg;

        vrow_we         = 1'b0;
        vrow_wdata      = vrow_eff;

        cmd.tag_raddr   = slot_index(bucket, next_way);
        cmd.tag_we      = 1'b0;
        cmd.tag_waddr   = slot_index(bucket, hit_way_reg);
        cmd.tag_wdata   = '{key: key_reg, ctx: ctx_reg,
                            mask: hit_mask_reg | (WORDS'(1) << widx_reg)};
        cmd.word_raddr  = {slot_index(bucket, way_reg), widx_reg};
        cmd.word_we     = 1'b0;
        cmd.word_waddr  = {slot_index(bucket, hit_way_reg), widx_reg};
        cmd.word_wdata  = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd.tag_raddr = slot_index(in_bucket, '0);
                if (accept)
                begin
                    op_next         = operation;
                    key_next        = key;
                    ctx_next        = context_req;
                    widx_next       = word_index;
                    value_next      = value;
                    way_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_LOOK;
                end
            end

            // one way compared per cycle, the next way's tag read meanwhile
            S_LOOK:
            begin
                if (!vrow_eff[way_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_way_next   = way_reg;
                end
                if (match)
                begin
                    hit_next      = 1'b1;
                    hit_way_next  = way_reg;
                    hit_mask_next = tag_rdata.mask;
                    state_next    = S_ACT;
                end
                else if (way_reg == LAST_WAY)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    way_next = next_way;
                end
            end

            // update the tables and register the result
            S_ACT:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_read_next  = '0;
                    out_hit_next   = 1'b0;
                    out_full_next  = 1'b0;
                    case (op_reg)
                        OP_WRITE:
                        begin
                            out_hit_next = hit_reg;
                            if (hit_reg)
                            begin
                                cmd.tag_we  = 1'b1;
                                cmd.word_we = 1'b1;
                            end
                            else if (free_found_reg)
                            begin
                                cmd.tag_we          = 1'b1;
                                cmd.tag_waddr       = slot_index(bucket, free_way_reg);
                                cmd.tag_wdata.mask  = WORDS'(1) << widx_reg;
                                cmd.word_we         = 1'b1;
                                cmd.word_waddr      = {slot_index(bucket, free_way_reg),
                                                       widx_reg};
                                vrow_we             = 1'b1;
                                vrow_wdata          = vrow_eff | (WAYS'(1) << free_way_reg);
                                row_init_next[bucket] = 1'b1;
                            end
                            else
                            begin
                                out_full_next = 1'b1;
                            end
                        end

                        OP_READ:
                        begin
                            out_hit_next = hit_reg;
                            // words never written since allocation read as zero
                            if (hit_reg && hit_mask_reg[widx_reg])
                            begin
                                out_read_next = word_rdata;
                            end
                        end

                        OP_DELETE:
                        begin
                            out_hit_next = hit_reg;
                            if (hit_reg)
                            begin
                                vrow_we               = 1'b1;
                                vrow_wdata            = vrow_eff & ~(WAYS'(1) << hit_way_reg);
                                row_init_next[bucket] = 1'b1;
                            end
                        end

                        default:
                        begin
                            out_hit_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_init_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_init_reg   <= row_init_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item payload and lookup results
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        ctx_reg        <= ctx_next;
        widx_reg       <= widx_next;
        value_reg      <= value_next;
        way_reg        <= way_next;
        hit_reg        <= hit_next;
        hit_way_reg    <= hit_way_next;
        hit_mask_reg   <= hit_mask_next;
        free_found_reg <= free_found_next;
        free_way_reg   <= free_way_next;
        out_read_reg   <= out_read_next;
        out_hit_reg    <= out_hit_next;
        out_full_reg   <= out_full_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign read_value  = out_read_reg;
    assign hit         = out_hit_reg;
    assign bucket_full = out_full_reg;

    // checks
    `TKHT_ASSERT_NOW(a_full_not_hit, out_valid_reg, !(out_hit_reg && out_full_reg), "full with hit")
    `TKHT_ASSERT_NOW(a_miss_reads_zero, out_valid_reg && !out_hit_reg, out_read_reg == '0, "miss data")
    `TKHT_ASSERT_NEXT(a_accept_to_look, accept, state_reg == S_LOOK, "no lookup after accept")
    `TKHT_ASSERT_NEXT(a_act_holds, (state_reg == S_ACT) && out_valid_reg && out_stall, (state_reg == S_ACT) && out_valid_reg, "result overwritten")
    `TKHT_ASSERT_NOW(a_way_range, state_reg == S_LOOK, way_reg <= LAST_WAY, "way out of range")

endmodule
